// ----- src/edsm_pkg.sv -----
// ---------------------------------------------------------------------------
// edsm_pkg: shared types for the swap-aware edit distance block
// Opcodes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package edsm_pkg;

    typedef enum logic [1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PFX_RD,
        ST_PFX_CHK,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_A,
        ST_CELL_RD,
        ST_CELL,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned SIM_W     = 17;
    localparam int unsigned DIST_W    = 9;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

endpackage
`default_nettype wire

// ----- src/edit_distance_with_swap_match_top.sv -----
// ---------------------------------------------------------------------------
// edit_distance_with_swap_match_top: swap-aware edit distance engine
// Loads two byte strings, then returns distance and Q16 similarity.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis beats carry the symbol in tdata and the opcode in tuser. Opcode 0
//   appends to string A, 1 appends to string B, 2 computes one result and
//   clears both strings, 3 is ignored. Appends are accepted back to back while
//   idle. Symbols past MAX_LEN are dropped and flagged in length_overflow.
//   A compute beat blocks s_axis while it runs: a read and a compare per
//   common prefix symbol, then the init of the cost column, then the
//   cost-column loop (one memory read then one write per cell), with la and
//   lb counted after the prefix; then the bit-serial divide (cut short when
//   both strings are empty) and the load of the result. The cell loop and the
//   single write port of the cost memory set the length of a compute.
//   m_axis carries {similarity_q16, distance} in tdata and length_overflow
//   in tuser. A result waits in the output register until taken; s_axis
//   reopens once the result is loaded, and a following compute holds in its
//   last cycle while the receiver stalls.
//   Reset clears lengths, overflow flag, fold_case and the sequencer; the
//   string and cost memories are not cleared. fold_case is at APB address 0.
// ---------------------------------------------------------------------------
`default_nettype none
module edit_distance_with_swap_match_top #(
    parameter int unsigned MAX_LEN = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [8:0] distance,
                                             // [25:9] similarity_q16
    output logic             m_axis_tuser,   // [0] length_overflow
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned AW = $clog2(MAX_LEN);      // string index
    localparam int unsigned LW = $clog2(MAX_LEN + 1);  // length
    localparam int unsigned CW = $clog2(MAX_LEN + 2);  // cost column index
    localparam int unsigned NW = LW + edsm_pkg::FRAC_BITS + 1;

    // config
    logic fold_case_reg;
    assign pready = 1'b1;
    assign prdata = {31'd0, fold_case_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_case_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            fold_case_reg <= pwdata[0];
    end

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        if (en && c >= edsm_pkg::CH_UPPER_A && c <= edsm_pkg::CH_UPPER_Z)
            return c + edsm_pkg::CASE_DELTA;
        return c;
    endfunction

    // memories
    logic [7:0]        mem_a [MAX_LEN];
    logic [7:0]        mem_b [MAX_LEN];
    logic [LW-1:0]     mem_c [MAX_LEN+1];
    logic [AW-1:0]     ra_addr, rb_addr, rb2_addr;
    logic [7:0]        ra_data, rb_data, rb2_data;
    logic [CW-1:0]     c_raddr, c_waddr;
    logic [LW-1:0]     c_wdata, c_rdata0, c_rdata1;
    logic              c_we;

    edsm_pkg::state_t state_reg, state_next;
    logic [LW-1:0] len_a_reg, len_b_reg;
    logic          ovf_reg;
    logic [LW-1:0] off_reg, off_next;
    logic [LW-1:0] i_reg, i_next, j_reg, j_next;
    logic [LW-1:0] cur_reg, cur_next, nxt_reg, nxt_next;
    logic [7:0]    ai_reg, ai_next, aprev_reg, aprev_next, bprev_reg, bprev_next;
    logic [LW-1:0] la_reg, la_next, lb_reg, lb_next, d_reg, d_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [edsm_pkg::SIM_W-1:0] q_reg, q_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [LW-1:0] mx;

    logic in_fire;
    edsm_pkg::opcode_t op;
    assign op = edsm_pkg::opcode_t'(s_axis_tuser);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign mx = (len_a_reg > len_b_reg) ? len_a_reg : len_b_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && op == edsm_pkg::OP_APPEND_A && len_a_reg < LW'(MAX_LEN))
            mem_a[len_a_reg[AW-1:0]] <= s_axis_tdata;
        if (in_fire && op == edsm_pkg::OP_APPEND_B && len_b_reg < LW'(MAX_LEN))
            mem_b[len_b_reg[AW-1:0]] <= s_axis_tdata;
        ra_data  <= mem_a[ra_addr];
        rb_data  <= mem_b[rb_addr];
        rb2_data <= mem_b[rb2_addr];
        if (c_we)
            mem_c[c_waddr] <= c_wdata;
        c_rdata0 <= mem_c[c_raddr];
        c_rdata1 <= mem_c[c_raddr + CW'(1)];
    end

    logic [LW-1:0] up1, left1, diag, best;
    logic free_sub;
    always_comb
    begin
        state_next = state_reg;
        off_next = off_reg; i_next = i_reg; j_next = j_reg;
        cur_next = cur_reg; nxt_next = nxt_reg;
        ai_next = ai_reg; aprev_next = aprev_reg; bprev_next = bprev_reg;
        la_next = la_reg; lb_next = lb_reg; d_next = d_reg;
        rem_next = rem_reg; num_next = num_reg; q_next = q_reg; cnt_next = cnt_reg;
        ra_addr = off_reg[AW-1:0];
        rb_addr = off_reg[AW-1:0];
        rb2_addr = '0;
        c_raddr = '0; c_waddr = '0; c_wdata = '0; c_we = 1'b0;
        up1 = '0; left1 = '0; diag = '0; best = '0; free_sub = 1'b0;
        s_axis_tready = 1'b0;
        case (state_reg)
            edsm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                off_next = '0;
                if (s_axis_tvalid && op == edsm_pkg::OP_COMPUTE)
                    state_next = edsm_pkg::ST_PFX_RD;
            end
            edsm_pkg::ST_PFX_RD:
            begin
                la_next = len_a_reg - off_reg;
                lb_next = len_b_reg - off_reg;
                if (off_reg == len_a_reg || off_reg == len_b_reg)
                begin
                    d_next = (off_reg == len_a_reg) ? len_b_reg - off_reg
                                                    : len_a_reg - off_reg;
                    state_next = edsm_pkg::ST_DIV;
                end
                else
                    state_next = edsm_pkg::ST_PFX_CHK;
                j_next = '0;
            end
            edsm_pkg::ST_PFX_CHK:
            begin
                if (fold(ra_data, fold_case_reg) == fold(rb_data, fold_case_reg))
                begin
                    off_next = off_reg + LW'(1);
                    state_next = edsm_pkg::ST_PFX_RD;
                end
                else
                    state_next = edsm_pkg::ST_INIT;
            end
            edsm_pkg::ST_INIT:
            begin
                c_we = 1'b1; c_waddr = CW'(j_reg); c_wdata = j_reg;
                j_next = j_reg + LW'(1);
                i_next = '0;
                if (j_reg == lb_reg)
                    state_next = edsm_pkg::ST_ROW_RD;
            end
            edsm_pkg::ST_ROW_RD:
            begin
                ra_addr = AW'(off_reg + i_reg);
                // tail entry of the row just finished
                if (i_reg != '0)
                begin
                    c_we = 1'b1; c_waddr = CW'(lb_reg); c_wdata = nxt_reg;
                end
                state_next = edsm_pkg::ST_ROW_A;
            end
            edsm_pkg::ST_ROW_A:
            begin
                aprev_next = ai_reg;
                ai_next = ra_data;
                cur_next = i_reg + LW'(1);
                j_next = '0;
                state_next = edsm_pkg::ST_CELL_RD;
            end
            edsm_pkg::ST_CELL_RD:
            begin
                c_raddr = CW'(j_reg);
                rb2_addr = AW'(off_reg + j_reg);
                state_next = edsm_pkg::ST_CELL;
            end
            edsm_pkg::ST_CELL:
            begin
                // swap: a[i-1]==b[j] and a[i]==b[j-1]
                free_sub = (fold(ai_reg, fold_case_reg) == fold(rb2_data, fold_case_reg))
                    || (i_reg != '0 && j_reg != '0
                        && fold(aprev_reg, fold_case_reg) == fold(rb2_data, fold_case_reg)
                        && fold(ai_reg, fold_case_reg) == fold(bprev_reg, fold_case_reg));
                up1 = c_rdata1 + LW'(1);
                left1 = cur_reg + LW'(1);
                diag = c_rdata0 + (free_sub ? LW'(0) : LW'(1));
                best = (up1 < left1) ? up1 : left1;
                best = (diag < best) ? diag : best;
                c_we = 1'b1; c_waddr = CW'(j_reg); c_wdata = cur_reg;
                cur_next = best;
                nxt_next = best;
                bprev_next = rb2_data;
                j_next = j_reg + LW'(1);
                if (j_reg + LW'(1) == lb_reg)
                begin
                    if (i_reg + LW'(1) == la_reg)
                    begin
                        d_next = best;
                        state_next = edsm_pkg::ST_DIV;
                    end
                    else
                    begin
                        i_next = i_reg + LW'(1);
                        state_next = edsm_pkg::ST_ROW_RD;
                    end
                end
                else
                    state_next = edsm_pkg::ST_CELL_RD;
            end
            edsm_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    num_next = NW'(mx - d_reg) << edsm_pkg::FRAC_BITS;
                    rem_next = '0; q_next = '0;
                    cnt_next = 6'(NW);
                end
                else
                begin
                    rem_next = {rem_reg[NW-2:0], num_reg[NW-1]};
                    num_next = num_reg << 1;
                    if (rem_next >= NW'(mx))
                    begin
                        rem_next = rem_next - NW'(mx);
                        q_next = {q_reg[edsm_pkg::SIM_W-2:0], 1'b1};
                    end
                    else
                        q_next = {q_reg[edsm_pkg::SIM_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_next = edsm_pkg::ST_OUT;
                end
                if (mx == '0)
                begin
                    q_next = edsm_pkg::SIM_W'(1) << edsm_pkg::FRAC_BITS;
                    cnt_next = '0;
                    state_next = edsm_pkg::ST_OUT;
                end
            end
            edsm_pkg::ST_OUT:
            begin
                if (m_axis_tready || !m_axis_tvalid)
                    state_next = edsm_pkg::ST_IDLE;
            end
            default: state_next = edsm_pkg::ST_IDLE;
        endcase
    end

    // result register loads when it is empty or being drained
    logic out_load;
    assign out_load = state_reg == edsm_pkg::ST_OUT && (m_axis_tready || !m_axis_tvalid);

    logic              out_v_reg;
    logic [25:0]       out_d_reg;
    logic              out_u_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {6'd0, out_d_reg};
    assign m_axis_tuser = out_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edsm_pkg::ST_IDLE;
            len_a_reg <= '0; len_b_reg <= '0; ovf_reg <= 1'b0;
            out_v_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (out_load)
                out_v_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_v_reg <= 1'b0;
            if (out_load)
            begin
                len_a_reg <= '0; len_b_reg <= '0; ovf_reg <= 1'b0;
            end
            else if (in_fire && op == edsm_pkg::OP_APPEND_A)
            begin
                if (len_a_reg < LW'(MAX_LEN)) len_a_reg <= len_a_reg + LW'(1);
                else ovf_reg <= 1'b1;
            end
            else if (in_fire && op == edsm_pkg::OP_APPEND_B)
            begin
                if (len_b_reg < LW'(MAX_LEN)) len_b_reg <= len_b_reg + LW'(1);
                else ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next; j_reg <= j_next; i_reg <= i_next;
        cur_reg <= cur_next; nxt_reg <= nxt_next;
        ai_reg <= ai_next; aprev_reg <= aprev_next; bprev_reg <= bprev_next;
        la_reg <= la_next; lb_reg <= lb_next;
        d_reg <= d_next;
        rem_reg <= rem_next; num_reg <= num_next; q_reg <= q_next;
        if (out_load)
        begin
            out_d_reg <= {q_reg, edsm_pkg::DIST_W'(d_reg)};
            out_u_reg <= ovf_reg;
        end
    end

endmodule
`default_nettype wire
